// ===== rtl/atatf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file setup package
// Shared register codes, opcodes, configuration and descriptor types.
// ----------------------------------------------------------------------------
package atatf_pkg;

    // Task-file register selects, in the order an LBA48 run writes them.
    localparam logic [3:0] REG_DEVSEL      = 4'd0;
    localparam logic [3:0] REG_SECCOUNT_HI = 4'd1;
    localparam logic [3:0] REG_LBA3        = 4'd2;
    localparam logic [3:0] REG_LBA4        = 4'd3;
    localparam logic [3:0] REG_LBA5        = 4'd4;
    localparam logic [3:0] REG_SECCOUNT    = 4'd5;
    localparam logic [3:0] REG_LBA0        = 4'd6;
    localparam logic [3:0] REG_LBA1        = 4'd7;
    localparam logic [3:0] REG_LBA2        = 4'd8;
    localparam logic [3:0] REG_COMMAND     = 4'd9;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_DRIVE  = 2'd1;
    localparam logic [1:0] STATUS_ATAPI     = 2'd2;

    // PIO command opcodes.
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // Device select base values.
    localparam logic [7:0] DEVSEL_CHS = 8'hA0;
    localparam logic [7:0] DEVSEL_LBA = 8'hE0;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PRESENT = 3'd0;
    localparam logic [2:0] CFG_ATAPI   = 3'd1;
    localparam logic [2:0] CFG_LBA     = 3'd2;
    localparam logic [2:0] CFG_SLAVE   = 3'd3;
    localparam logic [2:0] CFG_CHANNEL = 3'd4;

    // ceil(2^34 / 63): exact quotient by 63 for any 28-bit dividend.
    localparam logic [28:0] RECIP_63   = 29'd272696337;
    localparam int          RECIP_SHIFT = 34;

    typedef struct packed {
        logic [3:0] present;
        logic [3:0] atapi;
        logic [3:0] lba;
        logic [3:0] slave;
        logic [3:0] channel;
    } cfg_t;

    // One classified request, ready for the register-write sequencer.
    typedef struct packed {
        logic [1:0] status;
        logic       chan;
        logic       lba48;
        logic       wr;
        logic [7:0] devsel;
        logic [7:0] lba3;
        logic [7:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } desc_t;

endpackage

// ===== rtl/ata_taskfile_command_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file command setup
// Turns sector read/write requests into ordered task-file register writes.
// ----------------------------------------------------------------------------
// Each request (drive slot, start sector, sector count, direction) produces a
// run of register writes on the result side, one write per cycle while pop
// keeps up: ten for an LBA48 run (start sector at or above 2^28), six for
// LBA28 or CHS, and a single error result when the slot is above 3, absent,
// or ATAPI. The write sequencer in the back end emits one result per clock
// while pop keeps up, so that sequencer sets the sustained rate. The front
// end takes a request every cycle while its queue has room; a request passes
// the front-end register and a queue entry before its first write reaches the
// output register. The device masks are programmed over the APB port at byte
// addresses 0x00 to 0x10 and must be written only while no request is in flight.
// ----------------------------------------------------------------------------
module ata_taskfile_command_setup
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request side.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  drive_index,
    input  logic [31:0] start_sector,
    input  logic [7:0]  sector_total,
    input  logic        is_write,
    // Result side.
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        channel_select,
    output logic [3:0]  target_register,
    output logic [7:0]  write_value,
    output logic        last_write
);

    atatf_pkg::cfg_t  cfg_reg;
    atatf_pkg::cfg_t  cfg_next;
    logic             cfg_write;
    logic [2:0]       cfg_index;

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    atatf_pkg::desc_t q_wdata;
    atatf_pkg::desc_t q_rdata;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    // Register writes keep only the low four bits; unused indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                atatf_pkg::CFG_PRESENT: cfg_next.present = pwdata[3:0];
                atatf_pkg::CFG_ATAPI:   cfg_next.atapi   = pwdata[3:0];
                atatf_pkg::CFG_LBA:     cfg_next.lba     = pwdata[3:0];
                atatf_pkg::CFG_SLAVE:   cfg_next.slave   = pwdata[3:0];
                atatf_pkg::CFG_CHANNEL: cfg_next.channel = pwdata[3:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back of the masks.
    always_comb
    begin
        case (cfg_index)
            atatf_pkg::CFG_PRESENT: prdata = {28'd0, cfg_reg.present};
            atatf_pkg::CFG_ATAPI:   prdata = {28'd0, cfg_reg.atapi};
            atatf_pkg::CFG_LBA:     prdata = {28'd0, cfg_reg.lba};
            atatf_pkg::CFG_SLAVE:   prdata = {28'd0, cfg_reg.slave};
            atatf_pkg::CFG_CHANNEL: prdata = {28'd0, cfg_reg.channel};
            default:                prdata = 32'd0;
        endcase
    end

    // Front end: accepts requests and classifies them into descriptors.
    atatf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .drive_index  (drive_index),
        .start_sector (start_sector),
        .sector_total (sector_total),
        .is_write     (is_write),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    // Short queue so that the front end keeps taking requests while a long
    // run drains on the result side.
    atatf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop)
    );

    // Back end: emits the register writes through an output register.
    atatf_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .channel_select  (channel_select),
        .target_register (target_register),
        .write_value     (write_value),
        .last_write      (last_write)
    );

endmodule

// ===== rtl/atatf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file setup front end
// Accepts requests, checks the device masks and works out the addressing.
// ----------------------------------------------------------------------------
module atatf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  atatf_pkg::cfg_t   cfg,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        drive_index,
    input  logic [31:0]       start_sector,
    input  logic [7:0]        sector_total,
    input  logic              is_write,
    output logic              q_push,
    output atatf_pkg::desc_t  q_data,
    input  logic              q_full
);

    logic        a_valid_reg;
    logic        a_valid_next;
    logic        a_bad_reg;
    logic [1:0]  a_drive_reg;
    logic [31:0] a_lba_reg;
    logic [7:0]  a_count_reg;
    logic        a_wr_reg;
    logic [22:0] a_quot_reg;

    logic        accept;
    logic [56:0] product;
    logic [27:0] quot_x63;
    logic [27:0] rem_full;
    logic [7:0]  sect;
    logic [3:0]  head;
    logic        is_lba48;
    logic        use_lba;
    logic        slave;

    assign full   = a_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = a_valid_reg && !q_full;

    // The quotient by 63 comes from a reciprocal multiply; only the low
    // 28 address bits ever feed the cylinder/head/sector math.
    assign product = 57'(start_sector[27:0]) * 57'(atatf_pkg::RECIP_63);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_bad_reg   <= |drive_index[7:2];
            a_drive_reg <= drive_index[1:0];
            a_lba_reg   <= start_sector;
            a_count_reg <= sector_total;
            a_wr_reg    <= is_write;
            a_quot_reg  <= product[atatf_pkg::RECIP_SHIFT +: 23];
        end
    end

    assign quot_x63 = {a_quot_reg[21:0], 6'b0} - {5'b0, a_quot_reg};
    assign rem_full = a_lba_reg[27:0] - quot_x63;
    assign sect     = {2'b0, rem_full[5:0]} + 8'd1;
    assign is_lba48 = |a_lba_reg[31:28];
    assign use_lba  = cfg.lba[a_drive_reg];
    assign slave    = cfg.slave[a_drive_reg];

    always_comb
    begin
        q_data       = '0;
        q_data.wr    = a_wr_reg;
        q_data.count = a_count_reg;
        q_data.lba3  = a_lba_reg[31:24];
        q_data.lba48 = is_lba48;
        head         = 4'd0;
        if (a_bad_reg || !cfg.present[a_drive_reg])
        begin
            q_data.status = atatf_pkg::STATUS_NO_DRIVE;
        end
        else if (cfg.atapi[a_drive_reg])
        begin
            q_data.status = atatf_pkg::STATUS_ATAPI;
        end
        else
        begin
            q_data.status = atatf_pkg::STATUS_OK;
            q_data.chan   = cfg.channel[a_drive_reg];
            if (is_lba48 || use_lba)
            begin
                q_data.b0 = a_lba_reg[7:0];
                q_data.b1 = a_lba_reg[15:8];
                q_data.b2 = a_lba_reg[23:16];
                head      = is_lba48 ? 4'd0 : a_lba_reg[27:24];
                q_data.devsel = atatf_pkg::DEVSEL_LBA | {3'b0, slave, head};
            end
            else
            begin
                // Cylinder is the quotient by 1008, kept to 16 bits.
                q_data.b0 = sect;
                q_data.b1 = a_quot_reg[11:4];
                q_data.b2 = a_quot_reg[19:12];
                head      = a_quot_reg[3:0];
                q_data.devsel = atatf_pkg::DEVSEL_CHS | {3'b0, slave, head};
            end
        end
    end

endmodule

// ===== rtl/atatf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file setup descriptor queue
// Two-entry queue between the front end and the write sequencer.
// ----------------------------------------------------------------------------
module atatf_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  atatf_pkg::desc_t  q_wdata,
    output logic              q_full,
    output logic              q_valid,
    output atatf_pkg::desc_t  q_rdata,
    input  logic              q_pop
);

    atatf_pkg::desc_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign q_full  = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_rdata = mem[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wdata;
        end
    end

endmodule

// ===== rtl/atatf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA task-file setup write sequencer
// Walks each descriptor through its task-file writes, one per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module atatf_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  atatf_pkg::desc_t  q_rdata,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic              channel_select,
    output logic [3:0]        target_register,
    output logic [7:0]        write_value,
    output logic              last_write
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] status_reg;
    logic       chan_reg;
    logic [3:0] target_reg;
    logic [7:0] value_reg;
    logic       last_reg;
    logic [3:0] step_reg;
    logic [3:0] step_next;

    logic       load;
    logic       res_chan;
    logic [3:0] res_target;
    logic [7:0] res_value;
    logic       res_last;
    logic [7:0] cmd;

    assign load  = q_valid && (!out_valid_reg || pop);
    assign q_pop = load && res_last;
    assign empty = !out_valid_reg;

    always_comb
    begin
        if (q_rdata.wr)
        begin
            cmd = q_rdata.lba48 ? atatf_pkg::CMD_WRITE_EXT : atatf_pkg::CMD_WRITE;
        end
        else
        begin
            cmd = q_rdata.lba48 ? atatf_pkg::CMD_READ_EXT : atatf_pkg::CMD_READ;
        end
    end

    always_comb
    begin
        res_chan   = q_rdata.chan;
        res_target = step_reg;
        res_value  = 8'd0;
        res_last   = 1'b0;
        if (q_rdata.status != atatf_pkg::STATUS_OK)
        begin
            res_chan   = 1'b0;
            res_target = atatf_pkg::REG_DEVSEL;
            res_last   = 1'b1;
        end
        else
        begin
            case (step_reg)
                atatf_pkg::REG_DEVSEL:   res_value = q_rdata.devsel;
                atatf_pkg::REG_LBA3:     res_value = q_rdata.lba3;
                atatf_pkg::REG_SECCOUNT: res_value = q_rdata.count;
                atatf_pkg::REG_LBA0:     res_value = q_rdata.b0;
                atatf_pkg::REG_LBA1:     res_value = q_rdata.b1;
                atatf_pkg::REG_LBA2:     res_value = q_rdata.b2;
                atatf_pkg::REG_COMMAND:
                begin
                    res_value = cmd;
                    res_last  = 1'b1;
                end
                default:                 res_value = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (res_last)
            begin
                step_next = atatf_pkg::REG_DEVSEL;
            end
            else if (step_reg == atatf_pkg::REG_DEVSEL && !q_rdata.lba48)
            begin
                // Short runs skip the high-order LBA48 registers.
                step_next = atatf_pkg::REG_SECCOUNT;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= atatf_pkg::REG_DEVSEL;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= q_rdata.status;
            chan_reg   <= res_chan;
            target_reg <= res_target;
            value_reg  <= res_value;
            last_reg   <= res_last;
        end
    end

    assign status          = status_reg;
    assign channel_select  = chan_reg;
    assign target_register = target_reg;
    assign write_value     = value_reg;
    assign last_write      = last_reg;

    // A short run never visits the LBA48-only registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_rdata.lba48) |->
            !(step_reg == atatf_pkg::REG_SECCOUNT_HI || step_reg == atatf_pkg::REG_LBA3 ||
              step_reg == atatf_pkg::REG_LBA4 || step_reg == atatf_pkg::REG_LBA5))
        else $error("sequencer entered an LBA48 register on a short run");

    // A rejected request starts and ends on the first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_rdata.status != atatf_pkg::STATUS_OK) |->
            step_reg == atatf_pkg::REG_DEVSEL)
        else $error("rejected request found the sequencer mid-run");

    // An error result is always the whole run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != atatf_pkg::STATUS_OK) |-> last_reg)
        else $error("error result not marked as last");

    // The step counter is reset by every final write.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> step_reg == atatf_pkg::REG_DEVSEL)
        else $error("step counter not rewound after a run");

endmodule
